FILE: sv/lattice_neighbor_address_gen_defines.svh
// assertion macros for the lattice neighbour address generator
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef LATTICE_NEIGHBOR_ADDRESS_GEN_DEFINES_SVH
`define LATTICE_NEIGHBOR_ADDRESS_GEN_DEFINES_SVH

// check a property at every rising clock edge outside reset
`define LNAG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that a condition implies a consequent a fixed number of cycles later
`define LNAG_ASSERT_DLY(label, cond, dly, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond) |-> ##dly (cons)) else $error(msg);

`endif

FILE: sv/lnag_pkg.sv
// types, constants and the direction table of the lattice neighbour address generator
// no dependencies
`default_nettype none

package lnag_pkg;

  localparam int unsigned CoordW       = 10;
  localparam int unsigned SizeW        = 11;
  localparam int unsigned DirW         = 5;
  localparam int unsigned AddrW        = 30;
  localparam int unsigned AxisCellsMax = 1024;
  localparam int unsigned CfgAddrW     = 4;

  localparam logic [DirW-1:0] LastDir2d = DirW'(8);
  localparam logic [DirW-1:0] LastDir3d = DirW'(26);

  typedef enum logic [1:0] {
    RegMode  = 2'd0,
    RegXSize = 2'd1,
    RegYSize = 2'd2,
    RegZSize = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [CoordW-1:0] cell_x;
    logic [CoordW-1:0] cell_y;
    logic [CoordW-1:0] cell_z;
  } cell_t;

  typedef struct packed {
    logic [DirW-1:0]  direction;
    logic [AddrW-1:0] neighbor_address;
    logic             in_grid;
    logic             last_one;
  } result_t;

  // per-axis step, two's complement in two bits
  typedef struct packed {
    logic signed [1:0] dx;
    logic signed [1:0] dy;
    logic signed [1:0] dz;
  } offset_t;

  localparam logic signed [1:0] Pos  = 2'sb01;
  localparam logic signed [1:0] Neg  = 2'sb11;
  localparam logic signed [1:0] Zero = 2'sb00;

  function automatic offset_t dir_offset(input logic mode3d, input logic [DirW-1:0] k);
    offset_t off;
    off = '{Zero, Zero, Zero};
    if (mode3d) begin
      case (k)
        5'd1:    off = '{Pos,  Zero, Zero};
        5'd2:    off = '{Neg,  Zero, Zero};
        5'd3:    off = '{Zero, Zero, Pos};
        5'd4:    off = '{Zero, Zero, Neg};
        5'd5:    off = '{Zero, Pos,  Zero};
        5'd6:    off = '{Zero, Neg,  Zero};
        5'd7:    off = '{Pos,  Zero, Pos};
        5'd8:    off = '{Neg,  Zero, Pos};
        5'd9:    off = '{Pos,  Zero, Neg};
        5'd10:   off = '{Neg,  Zero, Neg};
        5'd11:   off = '{Pos,  Pos,  Zero};
        5'd12:   off = '{Neg,  Pos,  Zero};
        5'd13:   off = '{Pos,  Neg,  Zero};
        5'd14:   off = '{Neg,  Neg,  Zero};
        5'd15:   off = '{Zero, Pos,  Pos};
        5'd16:   off = '{Zero, Pos,  Neg};
        5'd17:   off = '{Zero, Neg,  Pos};
        5'd18:   off = '{Zero, Neg,  Neg};
        5'd19:   off = '{Pos,  Pos,  Pos};
        5'd20:   off = '{Neg,  Pos,  Pos};
        5'd21:   off = '{Pos,  Pos,  Neg};
        5'd22:   off = '{Neg,  Pos,  Neg};
        5'd23:   off = '{Pos,  Neg,  Pos};
        5'd24:   off = '{Neg,  Neg,  Pos};
        5'd25:   off = '{Pos,  Neg,  Neg};
        5'd26:   off = '{Neg,  Neg,  Neg};
        default: off = '{Zero, Zero, Zero};
      endcase
    end else begin
      case (k)
        5'd1:    off = '{Pos,  Zero, Zero};
        5'd2:    off = '{Zero, Pos,  Zero};
        5'd3:    off = '{Neg,  Zero, Zero};
        5'd4:    off = '{Zero, Neg,  Zero};
        5'd5:    off = '{Pos,  Pos,  Zero};
        5'd6:    off = '{Neg,  Pos,  Zero};
        5'd7:    off = '{Neg,  Neg,  Zero};
        5'd8:    off = '{Pos,  Neg,  Zero};
        default: off = '{Zero, Zero, Zero};
      endcase
    end
    return off;
  endfunction

endpackage

`default_nettype wire

FILE: sv/lattice_neighbor_address_gen.sv
// lattice neighbour address generator: direction sequencer, three-stage address pipeline
// depends on lnag_pkg and lattice_neighbor_address_gen_defines.svh
// the first result of an item is registered in stage 1, stage 2 and the output register after the edge that accepts it
// throughput: one result per cycle; an item gives 9 (2D) or 27 (3D) results, set by the
//   direction sequencer issuing one direction per cycle; next item taken on the last one
// the receiver cannot stall; results leave one per cycle with no backpressure
// reset: async active low, clears valid bits and loads mode 3D and all sizes to 1024
`default_nettype none

`include "lattice_neighbor_address_gen_defines.svh"

module lattice_neighbor_address_gen (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              start_i,
  input  wire lnag_pkg::cell_t             cell_i,
  output logic                             busy_o,
  output logic                             result_valid_o,
  output lnag_pkg::result_t                result_o,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire [lnag_pkg::CfgAddrW-1:0]     paddr,
  input  wire [31:0]                       pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  localparam logic [lnag_pkg::SizeW-1:0] SizeMax = lnag_pkg::SizeW'(lnag_pkg::AxisCellsMax);

  function automatic logic [lnag_pkg::SizeW-1:0] clamp_size(input logic [31:0] v);
    logic [lnag_pkg::SizeW-1:0] s;
    s = v[lnag_pkg::SizeW-1:0];
    return (s > SizeMax) ? SizeMax : s;
  endfunction

  // configuration registers
  logic                        mode_q;
  logic [lnag_pkg::SizeW-1:0]  x_size_q, y_size_q, z_size_q;
  logic                        cfg_wr;
  lnag_pkg::reg_idx_e          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = lnag_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b1;
      x_size_q <= SizeMax;
      y_size_q <= SizeMax;
      z_size_q <= SizeMax;
    end else if (cfg_wr) begin
      case (cfg_idx)
        lnag_pkg::RegMode:  mode_q   <= pwdata[0];
        lnag_pkg::RegXSize: x_size_q <= clamp_size(pwdata);
        lnag_pkg::RegYSize: y_size_q <= clamp_size(pwdata);
        lnag_pkg::RegZSize: z_size_q <= clamp_size(pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      lnag_pkg::RegMode:  prdata = {31'b0, mode_q};
      lnag_pkg::RegXSize: prdata = {21'b0, x_size_q};
      lnag_pkg::RegYSize: prdata = {21'b0, y_size_q};
      lnag_pkg::RegZSize: prdata = {21'b0, z_size_q};
      default:            prdata = 32'b0;
    endcase
  end

  // direction sequencer
  logic                       seq_active_q, seq_active_d;
  logic [lnag_pkg::DirW-1:0]  dir_q, dir_d;
  lnag_pkg::cell_t            cell_q, cell_d;
  logic                       seq_last;
  logic                       accept;

  assign seq_last = (dir_q == (mode_q ? lnag_pkg::LastDir3d : lnag_pkg::LastDir2d));
  assign busy_o   = seq_active_q && !seq_last;
  assign accept   = start_i && !busy_o;

  always_comb begin
    seq_active_d = seq_active_q;
    dir_d        = dir_q;
    cell_d       = cell_q;
    if (accept) begin
      seq_active_d = 1'b1;
      dir_d        = '0;
      cell_d       = cell_i;
    end else if (seq_active_q) begin
      if (seq_last) begin
        seq_active_d = 1'b0;
      end else begin
        dir_d = dir_q + lnag_pkg::DirW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_active_q <= 1'b0;
    end else begin
      seq_active_q <= seq_active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dir_q  <= dir_d;
    cell_q <= cell_d;
  end

  // stage 1: neighbour coordinates and grid check
  localparam int unsigned NW = lnag_pkg::CoordW + 2;

  lnag_pkg::offset_t          off;
  logic signed [NW-1:0]       nx, ny, nz;
  logic                       in_x, in_y, in_z;

  logic                       s1_valid_q;
  logic                       s1_mode_q, s1_last_q, s1_inside_q;
  logic [lnag_pkg::DirW-1:0]  s1_dir_q;
  logic [lnag_pkg::CoordW-1:0] s1_nx_q, s1_ny_q, s1_nz_q;

  assign off = lnag_pkg::dir_offset(mode_q, dir_q);
  assign nx  = $signed({2'b00, cell_q.cell_x}) + {{(NW-2){off.dx[1]}}, off.dx};
  assign ny  = $signed({2'b00, cell_q.cell_y}) + {{(NW-2){off.dy[1]}}, off.dy};
  assign nz  = $signed({2'b00, cell_q.cell_z}) + {{(NW-2){off.dz[1]}}, off.dz};

  // a neighbour inside the grid is below the size, so it fits the coordinate width
  assign in_x = !nx[NW-1] && (nx[NW-2:0] < x_size_q);
  assign in_y = !ny[NW-1] && (ny[NW-2:0] < y_size_q);
  assign in_z = !mode_q || (!nz[NW-1] && (nz[NW-2:0] < z_size_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= seq_active_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_mode_q   <= mode_q;
    s1_last_q   <= seq_last;
    s1_dir_q    <= dir_q;
    s1_inside_q <= in_x && in_y && in_z;
    s1_nx_q     <= nx[lnag_pkg::CoordW-1:0];
    s1_ny_q     <= ny[lnag_pkg::CoordW-1:0];
    s1_nz_q     <= nz[lnag_pkg::CoordW-1:0];
  end

  // stage 2: x*ysize + y
  localparam int unsigned LinW = lnag_pkg::CoordW + lnag_pkg::SizeW;
  localparam int unsigned PrdW = LinW + lnag_pkg::SizeW;

  logic [LinW-1:0]            lin;
  logic                       s2_valid_q;
  logic                       s2_mode_q, s2_last_q, s2_inside_q;
  logic [lnag_pkg::DirW-1:0]  s2_dir_q;
  logic [lnag_pkg::CoordW-1:0] s2_nz_q;
  logic [LinW-1:0]            s2_lin_q;

  assign lin = ({{lnag_pkg::SizeW{1'b0}}, s1_nx_q} * {{lnag_pkg::CoordW{1'b0}}, y_size_q})
             + {{lnag_pkg::SizeW{1'b0}}, s1_ny_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_mode_q   <= s1_mode_q;
    s2_last_q   <= s1_last_q;
    s2_dir_q    <= s1_dir_q;
    s2_inside_q <= s1_inside_q;
    s2_nz_q     <= s1_nz_q;
    s2_lin_q    <= lin;
  end

  // stage 3: (x*ysize + y)*zsize + z in 3D, output register
  logic [PrdW-1:0]            prd;
  logic [lnag_pkg::AddrW-1:0] addr;

  assign prd = ({{lnag_pkg::SizeW{1'b0}}, s2_lin_q} * {{LinW{1'b0}}, z_size_q})
             + {{(PrdW-lnag_pkg::CoordW){1'b0}}, s2_nz_q};

  always_comb begin
    if (!s2_inside_q) begin
      addr = '0;
    end else if (s2_mode_q) begin
      addr = prd[lnag_pkg::AddrW-1:0];
    end else begin
      addr = {{(lnag_pkg::AddrW-LinW){1'b0}}, s2_lin_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    result_o.direction        <= s2_dir_q;
    result_o.neighbor_address <= addr;
    result_o.in_grid          <= s2_inside_q;
    result_o.last_one         <= s2_last_q;
  end

  // checks
  `LNAG_ASSERT_DLY(a_issue_reaches_output, seq_active_q, 3, result_valid_o,
                   "issued direction did not reach the output")
  `LNAG_ASSERT(a_last_on_final_dir,
               (result_valid_o && result_o.last_one) |->
               (result_o.direction == lnag_pkg::LastDir2d ||
                result_o.direction == lnag_pkg::LastDir3d),
               "last_one on a direction that is not the final one")
  `LNAG_ASSERT(a_outside_zero_addr,
               (result_valid_o && !result_o.in_grid) |-> (result_o.neighbor_address == '0),
               "neighbour outside the grid with a nonzero address")
  `LNAG_ASSERT(a_dir_steps,
               (result_valid_o && !result_o.last_one) |=>
               (result_valid_o &&
                result_o.direction == $past(result_o.direction) + lnag_pkg::DirW'(1)),
               "directions of an item not contiguous")
  `LNAG_ASSERT(a_seq_stops,
               (seq_active_q && seq_last && !start_i) |=> !seq_active_q,
               "sequencer kept running past the last direction")

endmodule

`default_nettype wire
